@@ hw/rtl/intel_hex_record_loader_macros.svh @@
// Assertion macros shared by the loader's RTL files.
`ifndef INTEL_HEX_RECORD_LOADER_MACROS_SVH
`define INTEL_HEX_RECORD_LOADER_MACROS_SVH

// The expression must never hold while out of reset.
`define IHEX_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("ihex: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ihex: implication failed");

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ihex: next-cycle implication failed");

`endif

@@ hw/rtl/ihex_pkg.sv @@
// Types and constants shared by the Intel HEX loader modules.
package ihex_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CASE_MASK    = 8'hDF;
  localparam logic [7:0] DIGIT_LO     = 8'h30;
  localparam logic [7:0] DIGIT_HI     = 8'h39;
  localparam logic [7:0] ALPHA_LO     = 8'h41;
  localparam logic [7:0] ALPHA_HI     = 8'h46;
  localparam logic [7:0] TYPE_DATA    = 8'h00;
  localparam logic [7:0] TYPE_EOF     = 8'h01;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_COLON = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_TYPE  = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CSUM  = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic       eof;
    logic       colon;
    logic       newline;
    logic       hex;
    logic [3:0] value;
  } token_t;

endpackage

@@ hw/rtl/ihex_front.sv @@
// Front end: accepts characters and classifies them into tokens.
module ihex_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_file_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output ihex_pkg::token_t  token_o
);

  logic [7:0] folded;
  logic       is_dec;
  logic       is_alpha;

  always_comb begin
    folded   = (char_code_i > ihex_pkg::DIGIT_HI) ? (char_code_i & ihex_pkg::CASE_MASK)
                                                  : char_code_i;
    is_dec   = (folded >= ihex_pkg::DIGIT_LO) && (folded <= ihex_pkg::DIGIT_HI);
    is_alpha = (folded >= ihex_pkg::ALPHA_LO) && (folded <= ihex_pkg::ALPHA_HI);
    token_o.eof     = end_of_file_i;
    token_o.colon   = (char_code_i == ihex_pkg::CHAR_COLON);
    token_o.newline = (char_code_i == ihex_pkg::CHAR_NEWLINE);
    token_o.hex     = is_dec || is_alpha;
    token_o.value   = is_dec ? folded[3:0] : (folded[3:0] + 4'd9);
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

@@ hw/rtl/ihex_queue.sv @@
// Short token queue between the front end and the record parser.
`include "intel_hex_record_loader_macros.svh"

module ihex_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ihex_pkg::token_t  push_token_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ihex_pkg::token_t  pop_token_o
);

  localparam int unsigned PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountBits = $clog2(DEPTH + 1);
  localparam logic [CountBits-1:0] DepthCount = CountBits'(DEPTH);

  ihex_pkg::token_t     slots_q [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] ptr);
    logic [PtrBits-1:0] res;
    if (ptr == PtrBits'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrBits'(1);
    end
    return res;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CountBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_token_i;
    end
  end

  assign full_o      = (count_q == DepthCount);
  assign valid_o     = (count_q != '0);
  assign pop_token_o = slots_q[rd_ptr_q];

  `IHEX_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)
  `IHEX_ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, pop_i && !valid_o)

endmodule

@@ hw/rtl/ihex_parser.sv @@
// Back end: record parser with its result register.
`include "intel_hex_record_loader_macros.svh"

module ihex_parser #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  token_valid_i,
  input  ihex_pkg::token_t      token_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [ADDR_BITS-1:0]  write_address_o,
  output logic [7:0]            write_data_o
);

  ihex_pkg::phase_e phase_q, phase_d;
  logic [1:0]   digit_q, digit_d;
  logic [7:0]   len_q, len_d;
  logic [15:0]  load_q, load_d;
  logic         eof_rec_q, eof_rec_d;
  logic [15:0]  acc_q, acc_d;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   idx_q, idx_d;
  logic         stopped_q, stopped_d;

  logic                 out_valid_q, out_valid_d;
  ihex_pkg::kind_e      out_kind_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [7:0]           out_data_q;

  logic                 res_valid;
  ihex_pkg::kind_e      res_kind;
  logic [ADDR_BITS-1:0] res_addr;
  logic [7:0]           res_data;

  logic [15:0] acc_next;
  logic [7:0]  sum_field;
  logic [7:0]  idx_next;
  logic [15:0] addr_sum;
  logic        field_end;
  logic        fail;
  logic        done_ok;

  assign pop_o = token_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d   = phase_q;
    digit_d   = digit_q;
    len_d     = len_q;
    load_d    = load_q;
    eof_rec_d = eof_rec_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    stopped_d = stopped_q;
    res_valid = 1'b0;
    res_kind  = ihex_pkg::KIND_WRITE;
    res_addr  = '0;
    res_data  = '0;
    fail      = 1'b0;
    done_ok   = 1'b0;
    acc_next  = {acc_q[11:0], token_i.value};
    sum_field = sum_q + acc_next[7:0];
    idx_next  = idx_q + 8'd1;
    addr_sum  = load_q + {8'h00, idx_q};
    field_end = (phase_q == ihex_pkg::PH_ADDR) ? (digit_q == 2'd3) : (digit_q == 2'd1);

    if (pop_o && !stopped_q) begin
      if (token_i.eof) begin
        fail = 1'b1;
      end else begin
        unique case (phase_q) inside
          ihex_pkg::PH_COLON: begin
            if (!token_i.colon) begin
              fail = 1'b1;
            end else begin
              phase_d = ihex_pkg::PH_LEN;
              digit_d = '0;
              acc_d   = '0;
              sum_d   = '0;
              idx_d   = '0;
            end
          end
          ihex_pkg::PH_SKIP: begin
            if (token_i.newline) begin
              phase_d = ihex_pkg::PH_COLON;
            end
          end
          ihex_pkg::PH_LEN, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE,
          ihex_pkg::PH_DATA, ihex_pkg::PH_CSUM: begin
            if (!token_i.hex) begin
              fail = 1'b1;
            end else if (!field_end) begin
              digit_d = digit_q + 2'd1;
              acc_d   = acc_next;
            end else begin
              digit_d = '0;
              acc_d   = '0;
              case (phase_q)
                ihex_pkg::PH_LEN: begin
                  len_d   = acc_next[7:0];
                  sum_d   = sum_field;
                  phase_d = ihex_pkg::PH_ADDR;
                end
                ihex_pkg::PH_ADDR: begin
                  load_d  = acc_next;
                  sum_d   = sum_field + acc_next[15:8];
                  phase_d = ihex_pkg::PH_TYPE;
                end
                ihex_pkg::PH_TYPE: begin
                  sum_d     = sum_field;
                  eof_rec_d = (acc_next[7:0] == ihex_pkg::TYPE_EOF);
                  if (acc_next[7:0] == ihex_pkg::TYPE_EOF) begin
                    phase_d = ihex_pkg::PH_CSUM;
                  end else if (acc_next[7:0] == ihex_pkg::TYPE_DATA) begin
                    phase_d = (len_q != 8'h00) ? ihex_pkg::PH_DATA : ihex_pkg::PH_CSUM;
                  end else begin
                    fail = 1'b1;
                  end
                end
                ihex_pkg::PH_DATA: begin
                  sum_d     = sum_field;
                  idx_d     = idx_next;
                  res_valid = 1'b1;
                  res_kind  = ihex_pkg::KIND_WRITE;
                  res_addr  = addr_sum[ADDR_BITS-1:0];
                  res_data  = acc_next[7:0];
                  if (idx_next == len_q) begin
                    phase_d = ihex_pkg::PH_CSUM;
                  end
                end
                default: begin
                  sum_d = sum_field;
                  if (sum_field != 8'h00) begin
                    fail = 1'b1;
                  end else if (eof_rec_q) begin
                    done_ok = 1'b1;
                  end else begin
                    phase_d = ihex_pkg::PH_SKIP;
                  end
                end
              endcase
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase
      end
    end

    if (fail || done_ok) begin
      stopped_d = 1'b1;
      res_valid = 1'b1;
      res_kind  = fail ? ihex_pkg::KIND_ERROR : ihex_pkg::KIND_OK;
      res_addr  = '0;
      res_data  = '0;
    end

    out_valid_d = res_valid || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ihex_pkg::PH_COLON;
      digit_q     <= '0;
      len_q       <= '0;
      load_q      <= '0;
      eof_rec_q   <= 1'b0;
      acc_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      digit_q     <= digit_d;
      len_q       <= len_d;
      load_q      <= load_d;
      eof_rec_q   <= eof_rec_d;
      acc_q       <= acc_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_kind_q <= res_kind;
      out_addr_q <= res_addr;
      out_data_q <= res_data;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;

  `IHEX_ASSERT_NEXT(a_silent_once_stopped, clk_i, rst_ni,
                    stopped_q && !out_valid_q, !out_valid_q)
  `IHEX_ASSERT_IMP(a_status_zero_payload, clk_i, rst_ni,
                   out_valid_q && (out_kind_q != ihex_pkg::KIND_WRITE),
                   (out_addr_q == '0) && (out_data_q == 8'h00))
  `IHEX_ASSERT_IMP(a_status_means_stopped, clk_i, rst_ni,
                   out_valid_q && (out_kind_q != ihex_pkg::KIND_WRITE), stopped_q)

endmodule

@@ hw/rtl/intel_hex_record_loader.sv @@
// Intel HEX record loader: top level joining front end, queue and parser.
//
// The input channel takes one character of the file text per transfer, or an
// end-of-file marker, with in_valid_i and in_stall_o. The output channel gives
// program-memory writes and one final status (load finished or format error)
// with out_valid_o and out_stall_i.
// A character is classified and written into the queue in the cycle of its
// transfer; the parser then pops it from the queue and puts any result into
// the output register.
// Throughput is one character per cycle while the receiver does not stall;
// each character gives at most one result.
// When the receiver stalls, the result is held and the parser stops taking
// tokens; the queue of QUEUE_DEPTH tokens fills and then in_stall_o rises.
// After a status result all further input is taken and ignored.
// Reset clears the queue, the output valid flag and the parser, which then
// waits for the colon that opens a record.
module intel_hex_record_loader #(
  parameter int unsigned ADDR_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_file_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [ADDR_BITS-1:0] write_address_o,
  output logic [7:0]           write_data_o
);

  logic             push;
  logic             queue_full;
  logic             pop;
  logic             token_valid;
  ihex_pkg::token_t push_token;
  ihex_pkg::token_t pop_token;

  ihex_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_file_i (end_of_file_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .token_o       (push_token)
  );

  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_token_i (push_token),
    .full_o       (queue_full),
    .pop_i        (pop),
    .valid_o      (token_valid),
    .pop_token_o  (pop_token)
  );

  ihex_parser #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .token_valid_i   (token_valid),
    .token_i         (pop_token),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o)
  );

endmodule
